// ===== rtl/core/dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue unit
// Entry store geometry, action codes, command queue item and status codes.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 2;
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUMP_FWD   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DUMP_REV   = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CMD_PUSH_F,
    CMD_PUSH_B,
    CMD_POP_F,
    CMD_POP_B,
    CMD_DUMP_F,
    CMD_DUMP_B
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    data_t     value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_WAIT,
    BK_DUMP
  } back_state_t;

  // (a + b) mod DEPTH for a, b < DEPTH
  function automatic idx_t wrap_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t wrap_inc(input idx_t a);
    return (a == idx_t'(DEPTH - 1)) ? '0 : idx_t'(a + 1'b1);
  endfunction

  function automatic idx_t wrap_dec(input idx_t a);
    return (a == '0) ? idx_t'(DEPTH - 1) : idx_t'(a - 1'b1);
  endfunction

endpackage : dq_pkg
`default_nettype wire

// ===== rtl/core/dq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_if: channel interfaces of the double-ended queue unit
// Request channel (action, value) and result channel (value, status, last).
// ----------------------------------------------------------------------------
interface dq_in_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, output action, output value_in, input ready);
  modport sink   (input valid, input action, input value_in, output ready);
endinterface : dq_in_if

interface dq_out_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_out;
  logic [STAT_W-1:0]        status;
  logic                     last;

  modport source (output valid, output value_out, output status, output last,
                  input ready);
  modport sink   (input valid, input value_out, input status, input last,
                  output ready);
endinterface : dq_out_if
`default_nettype wire

// ===== rtl/core/dq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front: request decode
// Takes items from the input channel, maps actions to commands, drops
// unused action codes.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
  dq_in_if.sink in_ch,
  output logic  cq_wr_valid,
  input  logic  cq_wr_ready,
  output cmd_t  cq_wr_cmd
);

  logic      known;
  cmd_kind_t kind;

  always_comb begin
    known = 1'b1;
    kind  = CMD_PUSH_F;
    case (in_ch.action)
      ACT_PUSH_FRONT: kind = CMD_PUSH_F;
      ACT_PUSH_BACK:  kind = CMD_PUSH_B;
      ACT_POP_FRONT:  kind = CMD_POP_F;
      ACT_POP_BACK:   kind = CMD_POP_B;
      ACT_DUMP_FWD:   kind = CMD_DUMP_F;
      ACT_DUMP_REV:   kind = CMD_DUMP_B;
      default:        known = 1'b0;   // no result, no state change
    endcase
  end

  // unknown codes are taken as soon as the queue could take them
  assign in_ch.ready     = cq_wr_ready;
  assign cq_wr_valid     = in_ch.valid && known;
  assign cq_wr_cmd.kind  = kind;
  assign cq_wr_cmd.value = $unsigned(in_ch.value_in);

endmodule : dq_front
`default_nettype wire

// ===== rtl/core/dq_cmdq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cmdq: command queue
// Short FIFO between decode and execution.
// ----------------------------------------------------------------------------
module dq_cmdq import dq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_cmd
);

  cmd_t                entry_r [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_PTR_W:0]   cnt_r;
  logic                push, pop;

  assign wr_ready = (cnt_r != (CQ_PTR_W+1)'(CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wr_cmd;
  end

endmodule : dq_cmdq
`default_nettype wire

// ===== rtl/core/dq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back: command execution
// Owns the entry store, front slot and entry count; produces result items.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_t       q_cmd,
  dq_out_if.source   out_ch
);

  back_state_t state_r, state_nxt;
  idx_t        front_r, front_nxt;
  cnt_t        count_r, count_nxt;
  idx_t        k_r, k_nxt;
  logic        rev_r, rev_nxt;

  data_t       mem [DEPTH];
  data_t       rd_data_r;
  logic        wr_en, rd_en;
  idx_t        wr_addr, rd_addr;

  logic        ovld_r;
  data_t       oval_r;
  logic [STAT_W-1:0] ost_r;
  logic        olast_r;

  logic        out_free;
  logic        ld, ld_last;
  data_t       ld_val;
  logic [STAT_W-1:0] ld_st;
  cnt_t        cm1_full;
  idx_t        cnt_m1, k_inc;
  logic        is_full, is_empty;

  assign out_free = !ovld_r || out_ch.ready;
  assign cm1_full = count_r - 1'b1;
  assign cnt_m1   = cm1_full[IDX_W-1:0];
  assign k_inc    = idx_t'(k_r + 1'b1);
  assign is_full  = (count_r == cnt_t'(DEPTH));
  assign is_empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      front_r <= '0;
      count_r <= '0;
      k_r     <= '0;
      rev_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    rev_nxt   = rev_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    ld        = 1'b0;
    ld_val    = '0;
    ld_st     = ST_OK;
    ld_last   = 1'b1;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_PUSH_F, CMD_PUSH_B: begin
              ld = 1'b1;
              if (is_full) begin
                ld_st = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (q_cmd.kind == CMD_PUSH_F) begin
                  wr_addr   = wrap_dec(front_r);
                  front_nxt = wrap_dec(front_r);
                end else begin
                  wr_addr = wrap_add(front_r, count_r[IDX_W-1:0]);
                end
              end
            end
            CMD_POP_F, CMD_POP_B: begin
              if (is_empty) begin
                ld    = 1'b1;
                ld_st = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                count_nxt = cm1_full;
                state_nxt = BK_POP_WAIT;
                if (q_cmd.kind == CMD_POP_F) begin
                  rd_addr   = front_r;
                  front_nxt = wrap_inc(front_r);
                end else begin
                  rd_addr = wrap_add(front_r, cnt_m1);
                end
                if (count_r == cnt_t'(1)) front_nxt = '0;  // now empty
              end
            end
            CMD_DUMP_F, CMD_DUMP_B: begin
              if (is_empty) begin
                ld    = 1'b1;
                ld_st = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                k_nxt     = '0;
                rev_nxt   = (q_cmd.kind == CMD_DUMP_B);
                rd_addr   = wrap_add(front_r, (q_cmd.kind == CMD_DUMP_B) ? cnt_m1 : '0);
                state_nxt = BK_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_POP_WAIT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_val    = rd_data_r;
          state_nxt = BK_IDLE;
        end
      end
      BK_DUMP: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_val  = rd_data_r;
          ld_last = (k_r == cnt_m1);
          if (ld_last) begin
            state_nxt = BK_IDLE;
          end else begin
            k_nxt   = k_inc;
            rd_en   = 1'b1;
            rd_addr = wrap_add(front_r, rev_r ? idx_t'(cnt_m1 - k_inc) : k_inc);
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_cmd.value;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (ld) begin
      ovld_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      oval_r  <= ld_val;
      ost_r   <= ld_st;
      olast_r <= ld_last;
    end
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.value_out = $signed(oval_r);
  assign out_ch.status    = ost_r;
  assign out_ch.last      = olast_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0))
    else $error("empty deque with nonzero front slot");

  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DUMP) |-> ({1'b0, k_r} < {1'b0, count_r}))
    else $error("dump index past entry count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_cmd.kind == CMD_PUSH_F || q_cmd.kind == CMD_PUSH_B) && !is_full)
      |=> (count_r == cnt_t'($past(count_r) + 1'b1)))
    else $error("push did not grow the deque");
`endif

endmodule : dq_back
`default_nettype wire

// ===== rtl/core/double_ended_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue of signed 32-bit values
// Push/pop at either end, and dump of all entries in either direction.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one item per request: action (push front/back, pop
//    front/back, dump front-first/back-first) and value_in for pushes.
//    Action codes 6 and 7 are taken and dropped without a result.
//  - out_ch returns value_out, status (ok, empty, full) and last. Every
//    request gives one result, except a dump of a non-empty deque, which
//    gives one result per held entry with last set on the final one.
//  - Results: a push or an error result enters the result register as
//    execution takes its command; a pop result and a dump's first entry
//    follow the registered read of the entry store, then one entry per
//    cycle while out_ch takes them.
//  - Throughput: pushes and error results run at one item per cycle
//    while out_ch takes them; a pop waits on the registered store read;
//    during a dump the command queue fills and then holds off in_ch.
//  - A two-entry command queue sits between decode and execution, so
//    in_ch keeps taking items while a result waits in the output register.
//  - When out_ch stalls, the result register holds and execution waits.
//  - Reset (rst_n low, synchronous) empties the deque and command queue;
//    store contents are not cleared and never read before written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);

  // decode -> command queue
  logic cq_wr_valid, cq_wr_ready;
  cmd_t cq_wr_cmd;

  // command queue -> execution
  logic cq_rd_valid, cq_rd_pop;
  cmd_t cq_rd_cmd;

  dq_front u_front (
    .in_ch       (in_ch),
    .cq_wr_valid (cq_wr_valid),
    .cq_wr_ready (cq_wr_ready),
    .cq_wr_cmd   (cq_wr_cmd)
  );

  dq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cq_wr_valid),
    .wr_ready (cq_wr_ready),
    .wr_cmd   (cq_wr_cmd),
    .rd_valid (cq_rd_valid),
    .rd_pop   (cq_rd_pop),
    .rd_cmd   (cq_rd_cmd)
  );

  // execution owns the entry store and the result register
  dq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (cq_rd_valid),
    .q_pop   (cq_rd_pop),
    .q_cmd   (cq_rd_cmd),
    .out_ch  (out_ch)
  );

endmodule : double_ended_queue_unit
`default_nettype wire

// ===== verif/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb: self-checking bench for the deque unit
// A shadow deque predicts every result of each accepted request. The monitor
// checks all results in order against it, while both channels idle at random.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
  import dq_pkg::*;

  // action codes the unit takes and drops without a result
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam int TARGET_ITEMS = 410;
  localparam int LONG_HOLD_AT = 150;  // items taken before the long receiver hold
  localparam int LONG_HOLD    = 150;  // cycles of that hold
  localparam int SYNC_AT      = 250;  // sender waits for all results here
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    data_t            value;
    logic             wait_drained;  // hold this item until no result is owed
  } request_t;

  typedef struct packed {
    data_t             value;
    logic [STAT_W-1:0] status;
    logic              last;
  } deque_result_t;

  logic clk;
  logic rst_n = 1'b0;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow deque: circular store, front slot and fill count
  // --------------------------------------------------------------------------
  data_t         shadow_store [DEPTH];
  int            shadow_front = 0;
  int            shadow_count = 0;
  deque_result_t owed_results [$];

  request_t request_q [$];
  int       gen_fill = 0;     // fill level as seen by the stimulus builder
  int       n_built = 0;

  int mismatches = 0;
  int n_taken = 0;
  int n_push = 0, n_pop = 0, n_dump = 0, n_spare = 0;
  int n_full = 0, n_empty = 0, n_results = 0;
  int cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic owe(input data_t v, input logic [STAT_W-1:0] st, input logic lst);
    deque_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    owed_results.push_back(r);
  endtask

  // apply one accepted request to the shadow deque and queue its results
  task automatic apply_to_shadow(input logic [ACT_W-1:0] act, input data_t val);
    int    pos;
    data_t v;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        n_push++;
        if (shadow_count >= DEPTH) begin
          n_full++;
          owe('0, ST_FULL, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_store[shadow_front] = val;
          end else begin
            shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
          end
          shadow_count++;
          owe('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        n_pop++;
        if (shadow_count == 0) begin
          n_empty++;
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            v = shadow_store[shadow_front];
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            v = shadow_store[(shadow_front + shadow_count - 1) % DEPTH];
          end
          shadow_count--;
          // removing the only entry leaves a clean empty deque
          if (shadow_count == 0) begin
            shadow_front = 0;
          end
          owe(v, ST_OK, 1'b1);
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_REV: begin
        n_dump++;
        if (shadow_count == 0) begin
          n_empty++;
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < shadow_count; k++) begin
            pos = (act == ACT_DUMP_FWD) ? k : shadow_count - 1 - k;
            owe(shadow_store[(shadow_front + pos) % DEPTH], ST_OK,
                k == shadow_count - 1);
          end
        end
      end
      default: n_spare++;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input logic [ACT_W-1:0] act, input data_t val,
                             input logic sync = 1'b0);
    request_t r;
    r.action       = act;
    r.value        = val;
    r.wait_drained = sync;
    request_q.push_back(r);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
      ACT_POP_FRONT, ACT_POP_BACK:   if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
    if (act != ACT_SPARE_6 && act != ACT_SPARE_7) begin
      n_built++;
    end
  endtask

  function automatic logic [ACT_W-1:0] any_push();
    return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [ACT_W-1:0] any_pop();
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  function automatic logic [ACT_W-1:0] any_dump();
    return $urandom_range(0, 1) ? ACT_DUMP_FWD : ACT_DUMP_REV;
  endfunction

  task automatic build_directed();
    // every read-type action on an empty deque
    add_request(ACT_POP_FRONT, '0);
    add_request(ACT_POP_BACK, '0);
    add_request(ACT_DUMP_FWD, '0);
    add_request(ACT_DUMP_REV, '0);
    // single entry in and out, field extremes
    add_request(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    add_request(ACT_POP_BACK, '0);
    add_request(ACT_PUSH_BACK, 32'h8000_0000);
    add_request(ACT_POP_FRONT, '0);
    add_request(ACT_PUSH_BACK, 32'h0000_0000);
    add_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    add_request(ACT_PUSH_BACK, 32'h5555_5555);
    add_request(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    // spare codes must leave no trace
    add_request(ACT_SPARE_6, 32'h1234_5678);
    add_request(ACT_SPARE_7, 32'hFFFF_FFFF);
    add_request(ACT_DUMP_FWD, '0);
    add_request(ACT_DUMP_REV, '0);
    add_request(ACT_POP_FRONT, '0);
    add_request(ACT_POP_BACK, '0);
    add_request(ACT_POP_FRONT, '0);
    add_request(ACT_POP_BACK, '0);
    add_request(ACT_POP_BACK, '0);
  endtask

  task automatic build_random();
    int  kind;
    int  len;
    bit  first;
    bit  synced;
    logic sync;
    first  = 1'b1;
    synced = 1'b0;
    while (n_built < TARGET_ITEMS) begin
      kind = first ? 0 : $urandom_range(0, 9);
      // the first random item and one mid-run item wait for a full drain
      sync = first || (!synced && n_built >= SYNC_AT);
      if (sync && !first) synced = 1'b1;
      first = 1'b0;
      if (kind <= 1) begin
        // fill to the limit, overrun it by up to two pushes, then dump the full deque
        len = DEPTH - gen_fill + $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          add_request(any_push(), pick_value(), sync && i == 0);
        end
        add_request(any_dump(), pick_value());
      end else if (kind <= 3) begin
        // drain to empty and past it
        len = gen_fill + $urandom_range(1, 2);
        for (int i = 0; i < len; i++) begin
          add_request(any_pop(), pick_value(), sync && i == 0);
        end
      end else if (kind <= 7) begin
        // mixed traffic leaning toward pushes
        len = $urandom_range(4, 12);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: add_request(any_push(), pick_value(), sync && i == 0);
            4, 5, 6:    add_request(any_pop(), pick_value(), sync && i == 0);
            default:    add_request(any_dump(), pick_value(), sync && i == 0);
          endcase
        end
      end else begin
        // raw codes, spare ones included
        len = $urandom_range(2, 5);
        for (int i = 0; i < len; i++) begin
          add_request(ACT_W'($urandom_range(0, 7)), pick_value(), sync && i == 0);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: acceptance at the rising edge, new values at the falling edge
  // --------------------------------------------------------------------------
  bit taken_now = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    taken_now = rst_n && in_ch.valid && in_ch.ready;
    if (taken_now) begin
      apply_to_shadow(in_ch.action, in_ch.value_in);
      void'(request_q.pop_front());
      n_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !taken_now) begin
      // offered item not yet taken: hold it steady
    end else if (request_q.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (request_q[0].wait_drained && owed_results.size() != 0) begin
      in_ch.valid <= 1'b0;
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else begin
      in_ch.valid    <= 1'b1;
      in_ch.action   <= request_q[0].action;
      in_ch.value_in <= request_q[0].value;
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        // new burst; some gaps are zero so long back-to-back runs occur
        burst_left = $urandom_range(0, 15);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall modes that change at random, plus one long hold-off so
  // the command queue fills and in_ch backs up
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  int  mode_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_taken >= LONG_HOLD_AT) begin
      out_ch.ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 40);
      end
      mode_left--;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each result against the oldest owed one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d last=%0b",
                                  out_ch.value_out, out_ch.status, out_ch.last));
      end else begin
        exp_r = owed_results.pop_front();
        if (out_ch.value_out !== exp_r.value)
          report_mismatch($sformatf("result %0d value_out %h, expected %h",
                                    n_results, out_ch.value_out, exp_r.value));
        if (out_ch.status !== exp_r.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    n_results, out_ch.status, exp_r.status));
        if (out_ch.last !== exp_r.last)
          report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                    n_results, out_ch.last, exp_r.last));
      end
    end
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycles, owed_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, stimulus, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_PUSH_FRONT;
    in_ch.value_in = '0;
    out_ch.ready   = 1'b0;
    build_directed();
    build_random();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (request_q.size() != 0 || owed_results.size() != 0) begin
      @(posedge clk);
    end
    // room for any stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d pushes, %0d pops, %0d dumps, %0d spare codes",
             n_taken, n_push, n_pop, n_dump, n_spare);
    $display("Checked %0d results, %0d with full status, %0d with empty status",
             n_results, n_full, n_empty);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule : double_ended_queue_unit_tb

// ===== double_ended_queue_unit.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_if.sv
rtl/core/dq_front.sv
rtl/core/dq_cmdq.sv
rtl/core/dq_back.sv
rtl/core/double_ended_queue_unit.sv
verif/double_ended_queue_unit_tb.sv
